// File: rtl/hcbp_pkg.sv
// Shared constants, codes and control structs for the Huffman code bit packer.
`timescale 1ns / 1ps

package hcbp_pkg;

    localparam int SYMBOL_W         = 7;
    localparam int CODE_BITS_W      = 64;
    localparam int CODE_LENGTH_W    = 7;
    localparam int BYTE_W           = 8;
    localparam int NUM_SYMBOLS_DEF  = 128;
    localparam int MAX_CODE_LEN_DEF = 64;

    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_ENCODE = 2'd1,
        ACT_FLUSH  = 2'd2
    } action_t;

    // sequencer -> packer
    typedef struct packed {
        logic align;
        logic step;
        logic flush;
    } pack_ctrl_t;

    // packer -> sequencer
    typedef struct packed {
        logic pack_done;
        logic flush_done;
    } pack_stat_t;

endpackage

// File: rtl/hcbp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module hcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/hcbp_table.sv
// Code table: code/length RAM plus per-entry valid bits so unloaded lengths read as zero.
`timescale 1ns / 1ps

module hcbp_table
    import hcbp_pkg::*;
#(
    parameter int NUM_SYMBOLS  = NUM_SYMBOLS_DEF,
    parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic                             rd_en,
    input  logic [$clog2(NUM_SYMBOLS)-1:0]   addr,
    input  logic [MAX_CODE_LEN-1:0]          wr_code,
    input  logic [$clog2(MAX_CODE_LEN+1)-1:0] wr_len,
    output logic [MAX_CODE_LEN-1:0]          rd_code,
    output logic [$clog2(MAX_CODE_LEN+1)-1:0] rd_len
);

    localparam int LEN_W  = $clog2(MAX_CODE_LEN + 1);
    localparam int WORD_W = MAX_CODE_LEN + LEN_W;

    logic [NUM_SYMBOLS-1:0] valid_reg;
    logic [NUM_SYMBOLS-1:0] valid_next;
    logic                   rd_valid_reg;
    logic                   rd_valid_next;
    logic [WORD_W-1:0]      rd_word;

    hcbp_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_SYMBOLS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (addr),
        .wr_data ({wr_len, wr_code}),
        .rd_en   (rd_en),
        .rd_addr (addr),
        .rd_data (rd_word)
    );

    always_comb
    begin
        valid_next    = valid_reg;
        rd_valid_next = rd_valid_reg;
        if (wr_en)
        begin
            valid_next[addr] = 1'b1;
        end
        if (rd_en)
        begin
            rd_valid_next = valid_reg[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    assign rd_code = rd_word[MAX_CODE_LEN-1:0];
    assign rd_len  = rd_valid_reg ? rd_word[WORD_W-1:MAX_CODE_LEN] : '0;

endmodule

// File: rtl/hcbp_packer.sv
// Shared shifter: packs code bits into bytes; one boundary per cycle unless stalled.
`timescale 1ns / 1ps

module hcbp_packer
    import hcbp_pkg::*;
#(
    parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pack_ctrl_t                        ctrl,
    input  logic [MAX_CODE_LEN-1:0]           rd_code,
    input  logic [$clog2(MAX_CODE_LEN+1)-1:0] rd_len,
    output pack_stat_t                        stat,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [BYTE_W-1:0]                 out_byte,
    output logic                              last
);

    localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);

    logic [MAX_CODE_LEN-1:0] code_reg, code_next;
    logic [LEN_W-1:0]        remain_reg, remain_next;
    logic [BYTE_W-1:0]       pend_reg, pend_next;
    logic [2:0]              pcnt_reg, pcnt_next;
    logic                    out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]       out_byte_reg, out_byte_next;
    logic                    last_reg, last_next;

    logic              slot_free;
    logic [3:0]        free;
    logic [3:0]        take;
    logic [3:0]        cnt_sum;
    logic [BYTE_W-1:0] merged;
    logic [LEN_W-1:0]  remain_left;
    logic              step_emit;
    logic              step_go;
    logic              flush_emit;

    always_comb
    begin
        slot_free   = !out_valid_reg || !out_stall;
        free        = 4'(BYTE_W) - {1'b0, pcnt_reg};
        take        = (remain_reg < LEN_W'(free)) ? remain_reg[3:0] : free;
        // code is left-aligned with zero fill, so bits past the code end are zero
        merged      = pend_reg | (code_reg[MAX_CODE_LEN-1 -: BYTE_W] >> pcnt_reg);
        cnt_sum     = {1'b0, pcnt_reg} + take;
        remain_left = remain_reg - LEN_W'(take);
        step_emit   = (cnt_sum == 4'(BYTE_W));
        step_go     = ctrl.step && (!step_emit || slot_free);
        flush_emit  = ctrl.flush && (pcnt_reg != 3'd0) && slot_free;

        stat.pack_done  = step_go && (remain_left == '0);
        stat.flush_done = ctrl.flush && ((pcnt_reg == 3'd0) || slot_free);

        code_next      = code_reg;
        remain_next    = remain_reg;
        pend_next      = pend_reg;
        pcnt_next      = pcnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;

        if (ctrl.align)
        begin
            code_next   = rd_code << (LEN_W'(MAX_CODE_LEN) - rd_len);
            remain_next = rd_len;
        end

        if (step_go)
        begin
            code_next   = code_reg << take;
            remain_next = remain_left;
            if (step_emit)
            begin
                out_valid_next = 1'b1;
                out_byte_next  = merged;
                // another full byte needs at least eight more bits
                last_next      = (remain_left < LEN_W'(BYTE_W));
                pend_next      = '0;
                pcnt_next      = 3'd0;
            end
            else
            begin
                pend_next = merged;
                pcnt_next = cnt_sum[2:0];
            end
        end

        if (flush_emit)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = pend_reg;
            last_next      = 1'b1;
            pend_next      = '0;
            pcnt_next      = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remain_reg    <= '0;
            pend_reg      <= '0;
            pcnt_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            remain_reg    <= remain_next;
            pend_reg      <= pend_next;
            pcnt_reg      <= pcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg     <= code_next;
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last      = last_reg;

`ifndef SYNTHESIS
    a_emit_needs_slot : assert property (@(posedge clk) disable iff (!rst_n)
        (step_go && step_emit) || flush_emit |-> slot_free)
        else $error("byte emitted over an untaken output beat");

    a_flush_clears : assert property (@(posedge clk) disable iff (!rst_n)
        stat.flush_done |=> (pcnt_reg == 3'd0))
        else $error("pending bits left after flush");

    a_step_has_bits : assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.step |-> (remain_reg != '0))
        else $error("pack step with no code bits left");

    a_remain_bound : assert property (@(posedge clk) disable iff (!rst_n)
        remain_reg <= LEN_W'(MAX_CODE_LEN))
        else $error("remaining length above maximum code length");
`endif

endmodule

// File: rtl/huffman_code_bit_packer.sv
// Top level: input decode and sequencer for the Huffman code bit packer.
//
// Input channel (in_valid/in_stall) carries action, symbol, code_bits and
// code_length. A load writes one code table entry; a load or encode of a
// symbol beyond the table, and an undefined action, are dropped. An encode
// is accepted with the table read, the alignment shift is set up in the
// lookup state, then the shared packing shifter makes its passes in the pack
// state: ceil((pending + length) / 8) passes, at most 9, and none for an
// unloaded symbol. A flush emits any pending bits in the flush state.
// in_stall is high while an item is in flight.
// Output channel (out_valid/out_stall) carries out_byte, MSB = earliest bit,
// and last on the final byte of an item. The output register lets the
// packer run until the next byte is due; a stalled receiver then holds the
// packer until that byte can be registered.
// Reset clears the pending byte, the output valid flag and all table valid
// bits, so every symbol reads as unloaded until written; no sweep is needed.
`timescale 1ns / 1ps

module huffman_code_bit_packer
    import hcbp_pkg::*;
#(
    parameter int NUM_SYMBOLS  = NUM_SYMBOLS_DEF,
    parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               action,
    input  logic [SYMBOL_W-1:0]      symbol,
    input  logic [CODE_BITS_W-1:0]   code_bits,
    input  logic [CODE_LENGTH_W-1:0] code_length,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [BYTE_W-1:0]        out_byte,
    output logic                     last
);

    localparam int SYM_W  = $clog2(NUM_SYMBOLS);
    localparam int LEN_W  = $clog2(MAX_CODE_LEN + 1);
    localparam int SYM_XW = ((SYM_W > SYMBOL_W) ? SYM_W : SYMBOL_W) + 1;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_LOOKUP = 4'b0010,
        ST_PACK   = 4'b0100,
        ST_FLUSH  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic              accept;
    logic [SYM_XW-1:0] sym_x;
    logic              in_range;
    logic [LEN_W-1:0]  len_sat;
    logic              tbl_wr;
    logic              tbl_rd;
    logic [MAX_CODE_LEN-1:0] rd_code;
    logic [LEN_W-1:0]  rd_len;
    pack_ctrl_t        ctrl;
    pack_stat_t        stat;

    assign accept   = in_valid && !in_stall;
    assign sym_x    = SYM_XW'(symbol);
    assign in_range = (sym_x < SYM_XW'(NUM_SYMBOLS));
    assign len_sat  = (code_length > CODE_LENGTH_W'(MAX_CODE_LEN)) ?
                      LEN_W'(MAX_CODE_LEN) : code_length[LEN_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        tbl_wr     = 1'b0;
        tbl_rd     = 1'b0;
        ctrl       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    case (action)
                        ACT_LOAD:
                        begin
                            tbl_wr = in_range;
                        end
                        ACT_ENCODE:
                        begin
                            if (in_range)
                            begin
                                tbl_rd     = 1'b1;
                                state_next = ST_LOOKUP;
                            end
                        end
                        ACT_FLUSH:
                        begin
                            state_next = ST_FLUSH;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_LOOKUP:
            begin
                // unloaded symbol: nothing to pack
                ctrl.align = (rd_len != '0);
                state_next = (rd_len != '0) ? ST_PACK : ST_IDLE;
            end
            ST_PACK:
            begin
                ctrl.step = 1'b1;
                if (stat.pack_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FLUSH:
            begin
                ctrl.flush = 1'b1;
                if (stat.flush_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    hcbp_table #(
        .NUM_SYMBOLS  (NUM_SYMBOLS),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (tbl_wr && accept),
        .rd_en   (tbl_rd && accept),
        .addr    (sym_x[SYM_W-1:0]),
        .wr_code (code_bits[MAX_CODE_LEN-1:0]),
        .wr_len  (len_sat),
        .rd_code (rd_code),
        .rd_len  (rd_len)
    );

    hcbp_packer #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_packer (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .rd_code   (rd_code),
        .rd_len    (rd_len),
        .stat      (stat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .last      (last)
    );

`ifndef SYNTHESIS
    a_lookup_after_read : assert property (@(posedge clk) disable iff (!rst_n)
        (tbl_rd && accept) |=> (state_reg == ST_LOOKUP))
        else $error("table read not followed by lookup");

    a_pack_needs_len : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOKUP) && (rd_len == '0) |=> (state_reg == ST_IDLE))
        else $error("packing started for an unloaded symbol");

    a_no_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.step || ctrl.flush) |-> in_stall)
        else $error("input open while packer busy");
`endif

endmodule

// File: verif/tb_top.sv
// Testbench for the Huffman code bit packer: random and directed beats, scoreboard check.
`timescale 1ns / 1ps

module tb_top;
    import hcbp_pkg::*;

    localparam logic [1:0] ACT_UNDEF    = 2'd3;
    localparam int         RANDOM_ITEMS = 145;
    localparam int         QUIET_ITEMS  = 30;
    localparam int         SETTLE_CYCLES = 40;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              last;
    } packed_byte_t;

    // Tracks the code table and the partial byte, and queues the bytes due.
    class byte_packer_scoreboard;
        logic [CODE_BITS_W-1:0]   code_table [NUM_SYMBOLS_DEF];
        logic [CODE_LENGTH_W-1:0] length_table [NUM_SYMBOLS_DEF];
        logic [BYTE_W-1:0]        partial_byte;
        int                       partial_count;
        packed_byte_t             due_bytes [$];
        int                       errors;

        function new();
            for (int s = 0; s < NUM_SYMBOLS_DEF; s++)
            begin
                code_table[s]   = '0;
                length_table[s] = '0;
            end
            partial_byte  = '0;
            partial_count = 0;
            errors        = 0;
        endfunction

        function int pending();
            return due_bytes.size();
        endfunction

        function void note_input(logic [1:0] act, logic [SYMBOL_W-1:0] sym,
                                 logic [CODE_BITS_W-1:0] bits,
                                 logic [CODE_LENGTH_W-1:0] len);
            packed_byte_t        beat;
            logic [BYTE_W-1:0]   made [$];
            logic [CODE_BITS_W-1:0] code;
            int                  clen;

            if (act == ACT_LOAD)
            begin
                code_table[sym]   = bits;
                length_table[sym] = (len > CODE_LENGTH_W'(MAX_CODE_LEN_DEF)) ?
                                    CODE_LENGTH_W'(MAX_CODE_LEN_DEF) : len;
            end
            else if (act == ACT_ENCODE)
            begin
                code = code_table[sym];
                clen = length_table[sym];
                for (int i = clen; i > 0; i--)
                begin
                    partial_byte[BYTE_W - 1 - partial_count] = code[i - 1];
                    partial_count++;
                    if (partial_count == BYTE_W)
                    begin
                        made.push_back(partial_byte);
                        partial_byte  = '0;
                        partial_count = 0;
                    end
                end
            end
            else if (act == ACT_FLUSH)
            begin
                if (partial_count != 0)
                begin
                    made.push_back(partial_byte);
                    partial_byte  = '0;
                    partial_count = 0;
                end
            end
            // undefined action: nothing changes
            for (int k = 0; k < made.size(); k++)
            begin
                beat.data = made[k];
                beat.last = (k == made.size() - 1);
                due_bytes.push_back(beat);
            end
        endfunction

        function void check_result(logic [BYTE_W-1:0] data, logic last);
            packed_byte_t want;

            if (due_bytes.size() == 0)
            begin
                $display("%0t: unexpected byte, expected none, got %02h last %0b",
                         $time, data, last);
                errors++;
                return;
            end
            want = due_bytes.pop_front();
            if (data !== want.data)
            begin
                $display("%0t: out_byte mismatch, expected %02h, got %02h",
                         $time, want.data, data);
                errors++;
            end
            if (last !== want.last)
            begin
                $display("%0t: last mismatch, expected %0b, got %0b",
                         $time, want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [1:0]               action;
    logic [SYMBOL_W-1:0]      symbol;
    logic [CODE_BITS_W-1:0]   code_bits;
    logic [CODE_LENGTH_W-1:0] code_length;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [BYTE_W-1:0]        out_byte;
    logic                     last;

    bit                       quiet = 1'b0;
    int                       stall_left = 0;
    byte_packer_scoreboard    sb = new();

    huffman_code_bit_packer i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .symbol      (symbol),
        .code_bits   (code_bits),
        .code_length (code_length),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .last        (last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // receiver: random stall bursts between free-running stretches
    always @(negedge clk)
    begin
        if (quiet)
            out_stall <= 1'b0;
        else if (stall_left > 0)
            stall_left <= stall_left - 1;
        else if (out_stall)
        begin
            out_stall  <= 1'b0;
            stall_left <= $urandom_range(0, 19);
        end
        else if ($urandom_range(0, 2) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 13);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_input(action, symbol, code_bits, code_length);
            if (out_valid && !out_stall)
                sb.check_result(out_byte, last);
        end
    end

    task automatic send_beat(logic [1:0] act, logic [SYMBOL_W-1:0] sym,
                             logic [CODE_BITS_W-1:0] bits,
                             logic [CODE_LENGTH_W-1:0] len);
        int gap;

        gap = 0;
        if (!quiet && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 14);
        if (gap > 0)
        begin
            @(negedge clk) in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        action      <= act;
        symbol      <= sym;
        code_bits   <= bits;
        code_length <= len;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        @(negedge clk) in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        logic [SYMBOL_W-1:0]      loaded_syms [$];
        logic [SYMBOL_W-1:0]      sym;
        logic [CODE_LENGTH_W-1:0] len;
        logic [CODE_BITS_W-1:0]   bits;
        int                       pick;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        action      = ACT_LOAD;
        symbol      = '0;
        code_bits   = '0;
        code_length = '0;
        repeat (5) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // directed: unloaded symbol, empty flush, undefined action
        send_beat(ACT_ENCODE, 7'd5, '0, '0);
        send_beat(ACT_FLUSH, 7'd0, '0, '0);
        send_beat(ACT_UNDEF, 7'd127, '1, 7'd127);
        // full-length all-ones, single zero bit, saturated length, high junk bits, unused, seven-bit code
        send_beat(ACT_LOAD, 7'd0, '1, 7'd64);
        send_beat(ACT_LOAD, 7'd127, '0, 7'd1);
        send_beat(ACT_LOAD, 7'd1, 64'hA5C3_0F96_5A3C_F069, 7'd127);
        send_beat(ACT_LOAD, 7'd2, 64'hFFFF_FFFF_FFFF_FFF5, 7'd3);
        send_beat(ACT_LOAD, 7'd3, 64'h1234, 7'd0);
        send_beat(ACT_LOAD, 7'd4, 64'h55, 7'd7);
        send_beat(ACT_ENCODE, 7'd127, '1, 7'd127);
        send_beat(ACT_ENCODE, 7'd0, '0, '0);
        send_beat(ACT_FLUSH, 7'd0, '0, '0);
        send_beat(ACT_ENCODE, 7'd1, '0, '0);
        send_beat(ACT_ENCODE, 7'd2, '0, '0);
        send_beat(ACT_ENCODE, 7'd3, '0, '0);
        send_beat(ACT_ENCODE, 7'd4, '0, '0);
        send_beat(ACT_FLUSH, 7'd0, '0, '0);
        send_beat(ACT_FLUSH, 7'd0, '0, '0);
        send_beat(ACT_ENCODE, 7'd0, '0, '0);
        send_beat(ACT_ENCODE, 7'd4, '0, '0);
        send_beat(ACT_ENCODE, 7'd4, '0, '0);
        send_beat(ACT_UNDEF, 7'd4, '0, 7'd8);
        send_beat(ACT_LOAD, 7'd0, 64'h96, 7'd8);
        send_beat(ACT_ENCODE, 7'd0, '0, '0);
        send_beat(ACT_FLUSH, 7'd0, '0, '0);
        loaded_syms = '{7'd0, 7'd1, 7'd2, 7'd4, 7'd127};

        // sender holds off until the packer has drained
        wait_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 2)
                wait_drained();
            if (n == RANDOM_ITEMS - QUIET_ITEMS)
                quiet = 1'b1;
            pick = $urandom_range(0, 99);
            bits = {$urandom, $urandom};
            if (pick < 15)
            begin
                sym = SYMBOL_W'($urandom_range(0, NUM_SYMBOLS_DEF - 1));
                case ($urandom_range(0, 19))
                    0:       len = 7'd0;
                    1:       len = CODE_LENGTH_W'($urandom_range(MAX_CODE_LEN_DEF + 1, 127));
                    2, 3:    len = CODE_LENGTH_W'($urandom_range(13, MAX_CODE_LEN_DEF));
                    default: len = CODE_LENGTH_W'($urandom_range(1, 12));
                endcase
                if (len != 0)
                    loaded_syms.push_back(sym);
                send_beat(ACT_LOAD, sym, bits, len);
            end
            else if (pick < 85)
            begin
                if ($urandom_range(0, 9) < 8)
                    sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
                else
                    sym = SYMBOL_W'($urandom_range(0, NUM_SYMBOLS_DEF - 1));
                send_beat(ACT_ENCODE, sym, bits, CODE_LENGTH_W'($urandom_range(0, 127)));
            end
            else if (pick < 95)
                send_beat(ACT_FLUSH, SYMBOL_W'($urandom_range(0, 127)), bits,
                          CODE_LENGTH_W'($urandom_range(0, 127)));
            else
                send_beat(ACT_UNDEF, SYMBOL_W'($urandom_range(0, 127)), bits,
                          CODE_LENGTH_W'($urandom_range(0, 127)));
        end
        send_beat(ACT_FLUSH, 7'd0, '0, '0);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
